// File: hw/rtl/cppc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cppc_pkg
// Shared types and constants of the circle parity pixel classifier.
// ----------------------------------------------------------------------------
package cppc_pkg;

  localparam int COL_W     = 10;
  localparam int IDX_W     = 6;
  localparam int CX_W      = 16;
  localparam int RAD_W     = 15;
  localparam int ENTRY_W   = 2 * CX_W + RAD_W;
  localparam int COUNT_W   = 7;
  localparam int SIZE_W    = 11;
  localparam int CLASS_W   = 2;
  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_SIZE   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CIRCLE_COUNT = 1'd1;

  localparam logic [SIZE_W-1:0]  IMAGE_SIZE_RST   = 11'd300;
  localparam logic [COUNT_W-1:0] CIRCLE_COUNT_RST = 7'd54;

  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_PIXEL = 1'b1;

  localparam logic [CLASS_W-1:0] CLS_OUTSIDE = 2'd0;
  localparam logic [CLASS_W-1:0] CLS_EVEN    = 2'd1;
  localparam logic [CLASS_W-1:0] CLS_ODD     = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISK,
    ST_CHECK,
    ST_RUN,
    ST_DRAIN,
    ST_FINISH
  } cppc_state_t;

  typedef struct packed {
    logic tab_wr;
    logic capture;
    logic disk;
    logic check;
    logic issue;
    logic out_load;
  } cppc_cmd_t;

  typedef struct packed {
    logic on_disk;
    logic n_zero;
    logic idx_last;
    logic pipe_busy;
    logic out_free;
  } cppc_status_t;

endpackage

// File: hw/rtl/cppc_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cppc_table
// Circle table: one write port, one registered read port.
// ----------------------------------------------------------------------------
module cppc_table import cppc_pkg::*; #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic               clk,
  input  logic               wr_en,
  input  logic [AW-1:0]      wr_addr,
  input  logic [ENTRY_W-1:0] wr_data,
  input  logic               rd_en,
  input  logic [AW-1:0]      rd_addr,
  output logic [ENTRY_W-1:0] rd_data
);

  logic [ENTRY_W-1:0] mem_r [DEPTH];
  logic [ENTRY_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: hw/rtl/cppc_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cppc_datapath
// Configuration registers, disk test, circle test pipeline, result register.
// ----------------------------------------------------------------------------
module cppc_datapath import cppc_pkg::*; #(
  parameter int MAX_CIRCLES = 64,
  parameter int FRAC_BITS   = 12,
  parameter int MAX_SIZE    = 1024
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_W-1:0]       cfg_wdata,
  input  logic [COL_W-1:0]       in_column,
  input  logic [COL_W-1:0]       in_row,
  input  logic [IDX_W-1:0]       in_circle_index,
  input  logic signed [CX_W-1:0] in_center_x,
  input  logic signed [CX_W-1:0] in_center_y,
  input  logic [RAD_W-1:0]       in_circle_radius,
  input  cppc_cmd_t              cmd,
  output cppc_status_t           status,
  output logic [CLASS_W-1:0]     out_pixel_class,
  output logic [COUNT_W-1:0]     out_cover_count,
  output logic                   out_valid,
  input  logic                   out_stall
);

  localparam int AW  = (MAX_CIRCLES > 1) ? $clog2(MAX_CIRCLES) : 1;
  localparam int CW  = $clog2(MAX_CIRCLES + 1);
  localparam int SW  = $clog2(MAX_SIZE + 1);
  localparam int DW  = ((SW > COL_W + 1) ? SW : COL_W + 1) + 1;
  localparam int SQW = 2 * DW + 1;
  localparam int PW  = CX_W + SW + 1;
  localparam int XW  = ((DW + FRAC_BITS > PW) ? DW + FRAC_BITS : PW) + 1;
  localparam int QW  = 2 * XW;
  localparam int RW  = RAD_W + SW;
  localparam int RQW = 2 * RW;

  logic [SIZE_W-1:0]      image_size_r;
  logic [COUNT_W-1:0]     circle_count_r;
  logic [SW-1:0]          size_eff;
  logic [CW-1:0]          n_eff;
  logic signed [DW-1:0]   d_c, e_c;
  logic signed [DW-1:0]   d_r, e_r;
  logic [SW-1:0]          s_r;
  logic [CW-1:0]          n_r;
  logic [2*DW-1:0]        dd_r, ee_r;
  logic [2*SW-1:0]        ss_r;
  logic                   inside_c, inside_r;
  logic [AW-1:0]          idx_r;
  logic                   tab_wr_en;
  logic [ENTRY_W-1:0]     rd_data;
  logic signed [CX_W-1:0] rd_cx, rd_cy;
  logic [RAD_W-1:0]       rd_rad;
  logic                   v1_r, v2_r, v3_r;
  logic signed [PW-1:0]   pcx_r, pcy_r;
  logic [RW-1:0]          prs_r;
  logic signed [XW-1:0]   ds_c, es_c, dx_c, dy_c;
  logic [QW-1:0]          dxx_r, dyy_r;
  logic [RQW-1:0]         rr_r;
  logic                   hit_c;
  logic [CW-1:0]          cnt_r;
  logic                   out_valid_r;
  logic [CLASS_W-1:0]     pixel_class_r;
  logic [COUNT_W-1:0]     cover_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_size_r   <= IMAGE_SIZE_RST;
      circle_count_r <= CIRCLE_COUNT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_IMAGE_SIZE:   image_size_r   <= cfg_wdata[SIZE_W-1:0];
        REG_CIRCLE_COUNT: circle_count_r <= cfg_wdata[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (image_size_r == '0) begin
      size_eff = SW'(1);
    end else if (32'(image_size_r) > MAX_SIZE) begin
      size_eff = SW'(MAX_SIZE);
    end else begin
      size_eff = SW'(image_size_r);
    end
    if (32'(circle_count_r) > MAX_CIRCLES) begin
      n_eff = CW'(MAX_CIRCLES);
    end else begin
      n_eff = CW'(circle_count_r);
    end
  end

  assign d_c = $signed({{(DW-COL_W-1){1'b0}}, in_column, 1'b0})
             - $signed({{(DW-SW){1'b0}}, size_eff});
  assign e_c = $signed({{(DW-COL_W-1){1'b0}}, in_row, 1'b0})
             - $signed({{(DW-SW){1'b0}}, size_eff});

  // capture the pixel and the sizes in force for it
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      d_r <= d_c;
      e_r <= e_c;
      s_r <= size_eff;
      n_r <= n_eff;
    end
    if (cmd.disk) begin
      dd_r <= d_r * d_r;
      ee_r <= e_r * e_r;
      ss_r <= s_r * s_r;
    end
  end

  assign inside_c = (SQW'(dd_r) + SQW'(ee_r)) <= SQW'(ss_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inside_r <= 1'b0;
      idx_r    <= '0;
    end else begin
      if (cmd.check) begin
        inside_r <= inside_c;
      end
      if (cmd.capture) begin
        idx_r <= '0;
      end else if (cmd.issue) begin
        idx_r <= idx_r + AW'(1);
      end
    end
  end

  assign tab_wr_en = cmd.tab_wr && (32'(in_circle_index) < MAX_CIRCLES);

  cppc_table #(
    .DEPTH (MAX_CIRCLES),
    .AW    (AW)
  ) u_table (
    .clk     (clk),
    .wr_en   (tab_wr_en),
    .wr_addr (AW'(in_circle_index)),
    .wr_data ({in_center_x, in_center_y, in_circle_radius}),
    .rd_en   (cmd.issue),
    .rd_addr (idx_r),
    .rd_data (rd_data)
  );

  assign rd_cx  = rd_data[ENTRY_W-1 -: CX_W];
  assign rd_cy  = rd_data[RAD_W +: CX_W];
  assign rd_rad = rd_data[RAD_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= cmd.issue;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  // scale centre and radius by the image size
  always_ff @(posedge clk) begin
    pcx_r <= rd_cx * $signed({1'b0, s_r});
    pcy_r <= rd_cy * $signed({1'b0, s_r});
    prs_r <= rd_rad * s_r;
  end

  assign ds_c = XW'(d_r) <<< FRAC_BITS;
  assign es_c = XW'(e_r) <<< FRAC_BITS;
  assign dx_c = ds_c - XW'(pcx_r);
  assign dy_c = es_c - XW'(pcy_r);

  always_ff @(posedge clk) begin
    dxx_r <= dx_c * dx_c;
    dyy_r <= dy_c * dy_c;
    rr_r  <= prs_r * prs_r;
  end

  assign hit_c = (QW'(dxx_r) + (QW + 1)'(dyy_r)) <= (QW + 1)'(rr_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.capture) begin
      cnt_r <= '0;
    end else if (v3_r && hit_c) begin
      cnt_r <= cnt_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      cover_count_r <= COUNT_W'(cnt_r);
      if (!inside_r) begin
        pixel_class_r <= CLS_OUTSIDE;
      end else if (cnt_r[0]) begin
        pixel_class_r <= CLS_ODD;
      end else begin
        pixel_class_r <= CLS_EVEN;
      end
    end
  end

  assign status.on_disk   = inside_c;
  assign status.n_zero    = (n_r == '0);
  assign status.idx_last  = (CW'(idx_r) == (n_r - CW'(1)));
  assign status.pipe_busy = v1_r | v2_r | v3_r;
  assign status.out_free  = !out_valid_r || !out_stall;

  assign out_valid       = out_valid_r;
  assign out_pixel_class = pixel_class_r;
  assign out_cover_count = cover_count_r;

endmodule

// File: hw/rtl/cppc_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cppc_ctrl
// Sequencer: accepts requests, steps the disk test and the circle sweep.
// ----------------------------------------------------------------------------
module cppc_ctrl import cppc_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  input  logic         in_mode,
  output logic         in_stall,
  input  cppc_status_t status,
  output cppc_cmd_t    cmd
);

  cppc_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid && in_mode == MODE_PIXEL) begin
          state_nxt = ST_DISK;
        end
      end
      ST_DISK:  state_nxt = ST_CHECK;
      ST_CHECK: begin
        if (status.on_disk && !status.n_zero) begin
          state_nxt = ST_RUN;
        end else begin
          state_nxt = ST_FINISH;
        end
      end
      ST_RUN: begin
        if (status.idx_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!status.pipe_busy) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (status.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state_r)
      ST_IDLE: begin
        in_stall    = 1'b0;
        cmd.tab_wr  = in_valid && in_mode == MODE_LOAD;
        cmd.capture = in_valid && in_mode == MODE_PIXEL;
      end
      ST_DISK:   cmd.disk     = 1'b1;
      ST_CHECK:  cmd.check    = 1'b1;
      ST_RUN:    cmd.issue    = 1'b1;
      ST_FINISH: cmd.out_load = status.out_free;
      default: ;
    endcase
  end

endmodule

// File: hw/rtl/circle_parity_pixel_classifier.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circle_parity_pixel_classifier
// Counts the stored circles that cover a pixel of the unit disk and gives
// the parity class of that count.
// ----------------------------------------------------------------------------
// Load request: written to the table while idle. Pixel inside the disk with
// n > 0 circles: the circle test pipeline takes one circle a cycle from the
// single table read port, then drains; no new request is taken until the
// result is loaded. Outside the disk, or no circle to test: no sweep runs.
// Reset clears the sequencer, pipeline and result valid, and sets
// image_size to 300 and circle_count to 54; the circle table is not cleared.
module circle_parity_pixel_classifier import cppc_pkg::*; #(
  parameter int MAX_CIRCLES = 64,
  parameter int FRAC_BITS   = 12,
  parameter int MAX_SIZE    = 1024
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_W-1:0]       cfg_wdata,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   in_mode,
  input  logic [COL_W-1:0]       in_column,
  input  logic [COL_W-1:0]       in_row,
  input  logic [IDX_W-1:0]       in_circle_index,
  input  logic signed [CX_W-1:0] in_center_x,
  input  logic signed [CX_W-1:0] in_center_y,
  input  logic [RAD_W-1:0]       in_circle_radius,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [CLASS_W-1:0]     out_pixel_class,
  output logic [COUNT_W-1:0]     out_cover_count
);

  cppc_cmd_t    cmd;
  cppc_status_t status;

  cppc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_mode  (in_mode),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  cppc_datapath #(
    .MAX_CIRCLES (MAX_CIRCLES),
    .FRAC_BITS   (FRAC_BITS),
    .MAX_SIZE    (MAX_SIZE)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_column        (in_column),
    .in_row           (in_row),
    .in_circle_index  (in_circle_index),
    .in_center_x      (in_center_x),
    .in_center_y      (in_center_y),
    .in_circle_radius (in_circle_radius),
    .cmd              (cmd),
    .status           (status),
    .out_pixel_class  (out_pixel_class),
    .out_cover_count  (out_cover_count),
    .out_valid        (out_valid),
    .out_stall        (out_stall)
  );

  a_pixel_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_mode == MODE_PIXEL) |=> in_stall)
    else $error("input not held after a pixel request");

  a_outside_no_cover: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_pixel_class == CLS_OUTSIDE) |-> (out_cover_count == '0))
    else $error("cover count set for a pixel outside the disk");

  a_class_parity: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_pixel_class != CLS_OUTSIDE) |->
      (out_pixel_class == (out_cover_count[0] ? CLS_ODD : CLS_EVEN)))
    else $error("class does not match cover count parity");

  a_cover_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (32'(out_cover_count) <= MAX_CIRCLES))
    else $error("cover count exceeds table depth");

endmodule

// File: tb/circle_parity_pixel_classifier_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circle_parity_pixel_classifier_test
// Self-checking bench for the circle parity pixel classifier. It fills the
// circle table, runs directed pixels on the disk edge and beyond the image,
// then sends random loads and pixels over a range of image sizes and circle
// counts, extremes and out-of-range values included. It drives random gaps
// on the request side and random stalls on the result side. A scoreboard
// predicts the class and cover count of every pixel and checks each result
// in order.
// ----------------------------------------------------------------------------
module circle_parity_pixel_classifier_test;
  import cppc_pkg::*;

  localparam int SLOTS           = 64;
  localparam int FRAC            = 12;
  localparam int SIDE_MAX        = 1024;
  localparam int PHASES          = 10;
  localparam int ITEMS_PER_PHASE = 177;
  localparam int DRAIN_CYCLES    = 12;
  localparam int WATCHDOG_LIMIT  = 4000;

  typedef struct {
    logic                   mode;
    logic [COL_W-1:0]       column;
    logic [COL_W-1:0]       row;
    logic [IDX_W-1:0]       slot;
    logic signed [CX_W-1:0] cx;
    logic signed [CX_W-1:0] cy;
    logic [RAD_W-1:0]       radius;
  } pixel_request_t;

  typedef struct {
    logic [CLASS_W-1:0] pixel_class;
    logic [COUNT_W-1:0] cover_count;
  } cover_t;

  class cover_book;
    int unsigned size_reg;
    int unsigned count_reg;
    longint      tab_cx[SLOTS];
    longint      tab_cy[SLOTS];
    longint      tab_r[SLOTS];
    cover_t      pending[$];
    int          errors;

    function new();
      size_reg  = IMAGE_SIZE_RST;
      count_reg = CIRCLE_COUNT_RST;
      errors    = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, int unsigned value);
      if (idx == REG_IMAGE_SIZE) size_reg = value & ((1 << SIZE_W) - 1);
      else if (idx == REG_CIRCLE_COUNT) count_reg = value & ((1 << COUNT_W) - 1);
    endfunction

    function int side();
      if (size_reg < 1) return 1;
      if (size_reg > SIDE_MAX) return SIDE_MAX;
      return size_reg;
    endfunction

    function cover_t cover_of(logic [COL_W-1:0] col, logic [COL_W-1:0] row);
      longint s;
      longint d;
      longint e;
      longint dx;
      longint dy;
      longint rs;
      int     n;
      int     hits;
      cover_t res;
      s = side();
      n = (count_reg > SLOTS) ? SLOTS : count_reg;
      d = 2 * longint'(col) - s;
      e = 2 * longint'(row) - s;
      hits = 0;
      res.pixel_class = CLS_OUTSIDE;
      if (d * d + e * e <= s * s) begin
        for (int i = 0; i < n; i++) begin
          dx = (d << FRAC) - tab_cx[i] * s;
          dy = (e << FRAC) - tab_cy[i] * s;
          rs = tab_r[i] * s;
          if (dx * dx + dy * dy <= rs * rs) hits++;
        end
        res.pixel_class = hits[0] ? CLS_ODD : CLS_EVEN;
      end
      res.cover_count = COUNT_W'(hits);
      return res;
    endfunction

    function void take_request(pixel_request_t rq);
      if (rq.mode == MODE_LOAD) begin
        tab_cx[rq.slot] = rq.cx;
        tab_cy[rq.slot] = rq.cy;
        tab_r[rq.slot]  = rq.radius;
      end else begin
        pending.insert(pending.size(), cover_of(rq.column, rq.row));
      end
    endfunction

    function void match_result(logic [CLASS_W-1:0] cls, logic [COUNT_W-1:0] cnt);
      cover_t want;
      if (pending.size() == 0) begin
        $error("result with no pixel outstanding: pixel_class %0d cover_count %0d",
               cls, cnt);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (cls !== want.pixel_class) begin
        $error("pixel_class: expected %0d, actual %0d", want.pixel_class, cls);
        errors++;
      end
      if (cnt !== want.cover_count) begin
        $error("cover_count: expected %0d, actual %0d", want.cover_count, cnt);
        errors++;
      end
    endfunction
  endclass

  logic                   clk;
  logic                   rst_n            = 1'b0;
  logic                   cfg_we           = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index        = '0;
  logic [CFG_W-1:0]       cfg_wdata        = '0;
  logic                   in_valid         = 1'b0;
  logic                   in_stall;
  logic                   in_mode          = MODE_LOAD;
  logic [COL_W-1:0]       in_column        = '0;
  logic [COL_W-1:0]       in_row           = '0;
  logic [IDX_W-1:0]       in_circle_index  = '0;
  logic signed [CX_W-1:0] in_center_x      = '0;
  logic signed [CX_W-1:0] in_center_y      = '0;
  logic [RAD_W-1:0]       in_circle_radius = '0;
  logic                   out_valid;
  logic                   out_stall        = 1'b0;
  logic [CLASS_W-1:0]     out_pixel_class;
  logic [COUNT_W-1:0]     out_cover_count;

  cover_book      book;
  pixel_request_t seen;
  bit             calm        = 1'b0;
  int             stall_left  = 0;
  bit             stall_on    = 1'b0;
  int             pick;
  int             idle_cycles = 0;
  int             loads_taken = 0;
  int             pixels_taken = 0;
  int             class_tally[3] = '{0, 0, 0};

  circle_parity_pixel_classifier DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_mode          (in_mode),
    .in_column        (in_column),
    .in_row           (in_row),
    .in_circle_index  (in_circle_index),
    .in_center_x      (in_center_x),
    .in_center_y      (in_center_y),
    .in_circle_radius (in_circle_radius),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_pixel_class  (out_pixel_class),
    .out_cover_count  (out_cover_count)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  always @(posedge clk) begin
    if (stall_left == 0) begin
      pick = $urandom_range(0, 99);
      if (calm || pick < 50) begin
        stall_on   = 1'b0;
        stall_left = $urandom_range(1, 12);
      end else if (pick < 92) begin
        stall_on   = 1'b1;
        stall_left = $urandom_range(1, 3);
      end else begin
        stall_on   = 1'b1;
        stall_left = $urandom_range(10, 40);
      end
    end
    stall_left--;
    out_stall <= stall_on;
  end

  always @(posedge clk) begin
    if (in_valid && !in_stall) begin
      seen.mode   = in_mode;
      seen.column = in_column;
      seen.row    = in_row;
      seen.slot   = in_circle_index;
      seen.cx     = in_center_x;
      seen.cy     = in_center_y;
      seen.radius = in_circle_radius;
      book.take_request(seen);
      if (in_mode == MODE_LOAD) loads_taken++;
      else pixels_taken++;
    end
    if (out_valid && !out_stall) begin
      book.match_result(out_pixel_class, out_cover_count);
      if (out_pixel_class < 3) class_tally[out_pixel_class]++;
    end
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no request or result for %0d cycles", WATCHDOG_LIMIT);
      $display("tb: failure");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic pixel_request_t pixel(int col, int row);
    pixel_request_t rq;
    rq.mode   = MODE_PIXEL;
    rq.column = COL_W'(col);
    rq.row    = COL_W'(row);
    rq.slot   = IDX_W'($urandom);
    rq.cx     = CX_W'($urandom);
    rq.cy     = CX_W'($urandom);
    rq.radius = RAD_W'($urandom);
    return rq;
  endfunction

  function automatic pixel_request_t circle(int slot, int cx, int cy, int radius);
    pixel_request_t rq;
    rq.mode   = MODE_LOAD;
    rq.column = COL_W'($urandom);
    rq.row    = COL_W'($urandom);
    rq.slot   = IDX_W'(slot);
    rq.cx     = CX_W'(cx);
    rq.cy     = CX_W'(cy);
    rq.radius = RAD_W'(radius);
    return rq;
  endfunction

  // mostly circles on the scale of the unit disk, some over the full range
  function automatic pixel_request_t random_circle(int slot);
    if ($urandom_range(0, 99) < 85)
      return circle(slot, $urandom_range(0, 10000) - 5000,
                    $urandom_range(0, 10000) - 5000, $urandom_range(0, 5000));
    return circle(slot, $urandom, $urandom, $urandom);
  endfunction

  function automatic pixel_request_t random_request(int s);
    if ($urandom_range(0, 99) < 20) return random_circle($urandom_range(0, SLOTS - 1));
    if ($urandom_range(0, 99) < 85)
      return pixel($urandom_range(0, s - 1), $urandom_range(0, s - 1));
    return pixel($urandom_range(0, 1023), $urandom_range(0, 1023));
  endfunction

  task automatic send_request(input pixel_request_t rq);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_mode          <= rq.mode;
    in_column        <= rq.column;
    in_row           <= rq.row;
    in_circle_index  <= rq.slot;
    in_center_x      <= rq.cx;
    in_center_y      <= rq.cy;
    in_circle_radius <= rq.radius;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (book.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= CFG_W'(value);
    @(posedge clk);
    cfg_we <= 1'b0;
    book.set_reg(idx, value);
    @(posedge clk);
  endtask

  initial begin
    int unsigned phase_size[PHASES];
    int unsigned phase_count[PHASES];
    phase_size  = '{300, 1, 0, 1024, 2047, 2, 1023, 64, 0, 17};
    phase_count = '{54, 64, 5, 64, 127, 1, 0, 20, 0, 64};
    book = new();
    phase_size[8]  = $urandom_range(3, 200);
    phase_count[8] = $urandom_range(0, 64);
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // fill every slot before any pixel reads the table
    for (int i = 0; i < SLOTS; i++) send_request(random_circle(i));

    send_request(circle(0, 0, 0, 1 << FRAC));
    send_request(circle(1, 0, 0, 0));
    send_request(circle(2, -32768, 32767, 32767));
    send_request(circle(SLOTS - 1, 32767, -32768, 0));
    send_request(pixel(150, 150));
    send_request(pixel(150, 0));
    send_request(pixel(0, 150));
    send_request(pixel(299, 150));
    send_request(pixel(150, 299));
    send_request(pixel(300, 150));
    send_request(pixel(0, 0));
    send_request(pixel(1023, 1023));
    send_request(pixel(1023, 0));
    send_request(pixel(0, 1023));
    send_request(pixel(212, 256));

    for (int p = 0; p < PHASES; p++) begin
      if (p > 0) begin
        wait_drained();
        write_reg(REG_IMAGE_SIZE, phase_size[p]);
        write_reg(REG_CIRCLE_COUNT, phase_count[p]);
      end
      calm = (p % 4 == 3);
      repeat (ITEMS_PER_PHASE) send_request(random_request(book.side()));
    end
    wait_drained();

    $display("summary: %0d circle loads and %0d pixels over %0d register settings",
             loads_taken, pixels_taken, PHASES);
    $display("summary: results outside %0d, even %0d, odd %0d",
             class_tally[0], class_tally[1], class_tally[2]);
    if (book.errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
